### hdl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_decode, utf8d_emit and utf8_stream_decoder.
package utf8d_pkg;

    localparam int CP_W       = 21;
    localparam int BYTE_W     = 8;
    localparam int CP_TDATA_W = 24;

    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // Results caused by one input byte: up to three replacements for a broken
    // sequence, followed by at most one final result.
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_final;
        logic [CP_W-1:0] final_cp;
        logic            final_rep;
    } burst_t;

endpackage

### hdl/utf8d_decode.sv
// Sequence tracker of the UTF-8 stream decoder: holds the open sequence and
// turns each accepted byte into a burst of results. Depends on utf8d_pkg.
module utf8d_decode (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [utf8d_pkg::BYTE_W-1:0]    in_byte,
    output utf8d_pkg::burst_t               burst
);
    import utf8d_pkg::*;

    logic [1:0]      expected_reg, expected_next;
    logic [1:0]      taken_reg, taken_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic            in_seq;
    logic            is_cont;
    logic [1:0]      taken_inc;
    logic [CP_W-1:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg <= 2'd0;
            taken_reg    <= 2'd0;
            partial_reg  <= '0;
        end else if (accept) begin
            expected_reg <= expected_next;
            taken_reg    <= taken_next;
            partial_reg  <= partial_next;
        end
    end

    always_comb begin
        in_seq    = (expected_reg != 2'd0);
        is_cont   = (in_byte[7:6] == 2'b10);
        taken_inc = taken_reg + 2'd1;
        shifted   = {partial_reg[CP_W-7:0], in_byte[5:0]};

        expected_next   = expected_reg;
        taken_next      = taken_reg;
        partial_next    = partial_reg;
        burst.rep_cnt   = 2'd0;
        burst.has_final = 1'b0;
        burst.final_cp  = '0;
        burst.final_rep = 1'b0;

        if (in_seq && is_cont) begin
            if (taken_inc >= expected_reg) begin
                burst.has_final = 1'b1;
                burst.final_cp  = shifted;
                expected_next   = 2'd0;
                taken_next      = 2'd0;
                partial_next    = '0;
            end else begin
                taken_next   = taken_inc;
                partial_next = shifted;
            end
        end else begin
            // A broken sequence flushes the lead and every continuation taken.
            if (in_seq) begin
                burst.rep_cnt = (taken_reg == 2'd3) ? 2'd3 : taken_inc;
            end
            expected_next = 2'd0;
            taken_next    = 2'd0;
            partial_next  = '0;

            if (in_byte == '0) begin
                burst.has_final = 1'b0;
            end else if (in_byte[7] == 1'b0) begin
                burst.has_final = 1'b1;
                burst.final_cp  = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            end else if (in_byte[7:5] == 3'b110) begin
                expected_next = 2'd1;
                partial_next  = {{(CP_W-5){1'b0}}, in_byte[4:0]};
            end else if (in_byte[7:4] == 4'b1110) begin
                expected_next = 2'd2;
                partial_next  = {{(CP_W-4){1'b0}}, in_byte[3:0]};
            end else if (in_byte[7:3] == 5'b11110) begin
                expected_next = 2'd3;
                partial_next  = {{(CP_W-3){1'b0}}, in_byte[2:0]};
            end else begin
                burst.has_final = 1'b1;
                burst.final_cp  = REPL_CP;
                burst.final_rep = 1'b1;
            end
        end
    end

endmodule

### hdl/utf8d_emit.sv
// Result sequencer of the UTF-8 stream decoder: holds one pending burst and
// the output register, and sends one result per transfer. Depends on utf8d_pkg.
module utf8d_emit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  utf8d_pkg::burst_t               burst_in,
    output logic                            take_ok,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [utf8d_pkg::CP_W-1:0]      out_cp,
    output logic                            out_rep,
    output logic                            out_last
);
    import utf8d_pkg::*;

    burst_t          pend_reg, pend_next;
    logic            valid_reg, valid_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            rep_reg, rep_next;
    logic            last_reg, last_next;

    logic out_free;
    logic pend_empty;
    logic pend_one;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
            cp_reg    <= '0;
            rep_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            cp_reg    <= cp_next;
            rep_reg   <= rep_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        out_free   = !valid_reg || out_ready;
        pend_empty = (pend_reg.rep_cnt == 2'd0) && !pend_reg.has_final;
        pend_one   = ((pend_reg.rep_cnt == 2'd0) && pend_reg.has_final) ||
                     ((pend_reg.rep_cnt == 2'd1) && !pend_reg.has_final);
        // A new byte fits once the pending burst is gone or leaves this cycle.
        take_ok    = pend_empty || (pend_one && out_free);

        pend_next  = pend_reg;
        valid_next = valid_reg;
        cp_next    = cp_reg;
        rep_next   = rep_reg;
        last_next  = last_reg;

        if (out_free) begin
            valid_next = !pend_empty;
            if (pend_reg.rep_cnt != 2'd0) begin
                cp_next           = REPL_CP;
                rep_next          = 1'b1;
                last_next         = (pend_reg.rep_cnt == 2'd1) && !pend_reg.has_final;
                pend_next.rep_cnt = pend_reg.rep_cnt - 2'd1;
            end else if (pend_reg.has_final) begin
                cp_next             = pend_reg.final_cp;
                rep_next            = pend_reg.final_rep;
                last_next           = 1'b1;
                pend_next.has_final = 1'b0;
            end
        end

        if (load) begin
            pend_next = burst_in;
        end
    end

    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_rep   = rep_reg;
    assign out_last  = last_reg;

endmodule

### hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: sequence tracker plus result sequencer.
// Depends on utf8d_pkg, utf8d_decode and utf8d_emit.
//
// Usage:
//   The slave channel takes one raw string byte per transfer in s_tdata; a
//   zero byte ends the string and flushes any open sequence. The master
//   channel delivers decoded code points in m_tdata, with m_tuser set on a
//   U+FFFD that stands for an error and m_tlast on the final result caused
//   by an input byte. A byte yields zero to four results.
//   The burst of a byte passes through the pending register and then the
//   output register before m_tvalid rises. A byte that yields at most one
//   result is taken every cycle while the master side is ready; a byte that
//   yields n results holds s_tready low while the output register drains the
//   pending burst, one result per cycle while m_tready is high.
//   When the receiver stalls, the output register keeps its result and one
//   more byte's burst is taken into the pending register; once that burst
//   holds a result, s_tready drops until the master side moves again.
//   Reset clears the open sequence and drops any pending results.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] codepoint, [23:21] zero
    output logic [0:0]  m_tuser,   // [0] is_replacement
    output logic        m_tlast    // last_of_run
);
    import utf8d_pkg::*;

    logic            accept;
    burst_t          burst;
    logic [CP_W-1:0] cp;
    logic            rep;

    assign accept = s_tvalid && s_tready;

    utf8d_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .burst   (burst)
    );

    utf8d_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .burst_in  (burst),
        .take_ok   (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cp    (cp),
        .out_rep   (rep),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(CP_TDATA_W-CP_W){1'b0}}, cp};
    assign m_tuser = rep;

`ifndef ASSERT_OFF
    a_repl_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[CP_W-1:0] == REPL_CP)
        else $error("replacement flag on a result that is not U+FFFD");

    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast && !m_tready |-> !s_tready)
        else $error("input taken while a stalled run still has results pending");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
